FILE: hdl/nucleotide_bigram_counter_defines.svh
// Assertion macros for the nucleotide bigram counter control module.
`ifndef NUCLEOTIDE_BIGRAM_COUNTER_DEFINES_SVH
`define NUCLEOTIDE_BIGRAM_COUNTER_DEFINES_SVH

// Condition and consequence in the same cycle.
`define NBC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequence in the cycle after the condition.
`define NBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/nbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package nbc_pkg;

  localparam int COUNT_WIDTH_DEF       = 48;
  localparam int LINE_LENGTH_WIDTH_DEF = 16;

  localparam int NUM_COUNTERS = 23;
  localparam int INDEX_W      = 5;
  localparam int VALUE_W      = 48;

  localparam logic [1:0] OP_CHAR    = 2'd0;
  localparam logic [1:0] OP_EOL     = 2'd1;
  localparam logic [1:0] OP_READOUT = 2'd2;

  localparam int IDX_BIGRAM0 = 4;
  localparam int IDX_LINES   = 20;
  localparam int IDX_LENGTH  = 21;
  localparam int IDX_SQUARE  = 22;

  localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(NUM_COUNTERS - 1);

  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_C = 8'h43;
  localparam logic [7:0] CHAR_T = 8'h54;
  localparam logic [7:0] CHAR_G = 8'h47;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] symbol;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0] counter_index;
    logic [VALUE_W-1:0] count_value;
    logic               last;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_READOUT
  } state_t;

  typedef struct packed {
    logic               char_en;
    logic               eol_en;
    logic               sq_en;
    logic               shift_en;
    logic [INDEX_W-1:0] index;
    logic               last;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  // Bit 2 flags a nucleotide, bits 1-0 give its code (A, C, T, G = 0..3).
  function automatic logic [2:0] code_of(input logic [7:0] sym);
    logic [7:0] up;
    up = sym;
    if (sym >= 8'h61 && sym <= 8'h7a) begin
      up = sym - 8'd32;
    end
    if (up == CHAR_A) begin
      code_of = 3'b100;
    end else if (up == CHAR_C) begin
      code_of = 3'b101;
    end else if (up == CHAR_T) begin
      code_of = 3'b110;
    end else if (up == CHAR_G) begin
      code_of = 3'b111;
    end else begin
      code_of = 3'b000;
    end
  endfunction

endpackage

`default_nettype wire

FILE: hdl/nucleotide_bigram_counter.sv
// Nucleotide bigram counter.
// Input channel (in_valid, in_ready, in_data): one item is a character
// (op 0), an end of line (op 1) or a readout request (op 2); op 3 is ignored.
// Output channel (out_valid, out_ready, out_data): only a readout produces
// items, 23 of them in counter order, with last set on the final one.
// Characters stream at one per cycle when no readout or squaring blocks input.
// An end of line is handled in two steps: the line length is squared into the
// square register, and the square is then added to its total in the square
// state, through one multiplier. A readout shifts the counter chain out one
// item per cycle into the output register while the receiver does not stall,
// once the accepted request has put the sequencer in its readout state.
// Input is not taken during a readout or the square cycle of an end of line.
// When the receiver stalls, the held item stays in the output register and
// the chain stops shifting; input resumes once the last item is registered.
// All counters saturate and are cleared by a readout, while the line in
// progress is kept. Synchronous reset clears every counter and line state.
`timescale 1ns / 1ps
`default_nettype none

module nucleotide_bigram_counter #(
  parameter int COUNT_WIDTH       = nbc_pkg::COUNT_WIDTH_DEF,
  parameter int LINE_LENGTH_WIDTH = nbc_pkg::LINE_LENGTH_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire nbc_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output nbc_pkg::out_item_t      out_data
);

  // Commands from the sequencer and the output-register status back to it.
  nbc_pkg::dp_cmd_t    cmd;
  nbc_pkg::dp_status_t status;

  nbc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.op),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Counter chain, line state, square register and output register.
  nbc_datapath #(
    .COUNT_WIDTH       (COUNT_WIDTH),
    .LINE_LENGTH_WIDTH (LINE_LENGTH_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: hdl/nbc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

`include "nucleotide_bigram_counter_defines.svh"

module nbc_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic [1:0]           in_op,
  output logic                      in_ready,
  input  wire nbc_pkg::dp_status_t  status,
  output nbc_pkg::dp_cmd_t          cmd
);

  nbc_pkg::state_t state_r, state_nxt;
  logic [nbc_pkg::INDEX_W-1:0] rd_cnt_r, rd_cnt_nxt;
  logic accept;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= nbc_pkg::ST_IDLE;
      rd_cnt_r <= '0;
    end else begin
      state_r  <= state_nxt;
      rd_cnt_r <= rd_cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      nbc_pkg::ST_IDLE: begin
        if (accept && in_op == nbc_pkg::OP_EOL) begin
          state_nxt = nbc_pkg::ST_SQUARE;
        end else if (accept && in_op == nbc_pkg::OP_READOUT) begin
          state_nxt = nbc_pkg::ST_READOUT;
        end
      end
      nbc_pkg::ST_SQUARE: begin
        state_nxt = nbc_pkg::ST_IDLE;
      end
      nbc_pkg::ST_READOUT: begin
        if (status.out_free && rd_cnt_r == nbc_pkg::LAST_INDEX) begin
          state_nxt = nbc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = nbc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    rd_cnt_nxt   = rd_cnt_r;
    cmd          = '0;
    cmd.index    = rd_cnt_r;
    cmd.last     = (rd_cnt_r == nbc_pkg::LAST_INDEX);
    case (state_r)
      nbc_pkg::ST_IDLE: begin
        // The input is always ready here, so valid alone marks an accepted item.
        in_ready    = 1'b1;
        cmd.char_en = in_valid && (in_op == nbc_pkg::OP_CHAR);
        cmd.eol_en  = in_valid && (in_op == nbc_pkg::OP_EOL);
        rd_cnt_nxt  = '0;
      end
      nbc_pkg::ST_SQUARE: begin
        cmd.sq_en = 1'b1;
      end
      nbc_pkg::ST_READOUT: begin
        cmd.shift_en = status.out_free;
        if (status.out_free) begin
          rd_cnt_nxt = rd_cnt_r + 1'b1;
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  `NBC_ASSERT_SAME(a_rd_cnt_range, clk, rst_n,
                   state_r == nbc_pkg::ST_READOUT,
                   rd_cnt_r <= nbc_pkg::LAST_INDEX,
                   "readout index out of range")
  `NBC_ASSERT_NEXT(a_square_one_cycle, clk, rst_n,
                   state_r == nbc_pkg::ST_SQUARE,
                   state_r == nbc_pkg::ST_IDLE,
                   "square update took more than one cycle")
  `NBC_ASSERT_NEXT(a_last_ends_readout, clk, rst_n,
                   cmd.shift_en && cmd.last,
                   state_r == nbc_pkg::ST_IDLE,
                   "readout did not end after last counter")

endmodule

`default_nettype wire

FILE: hdl/nbc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module nbc_datapath #(
  parameter int COUNT_WIDTH       = nbc_pkg::COUNT_WIDTH_DEF,
  parameter int LINE_LENGTH_WIDTH = nbc_pkg::LINE_LENGTH_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire nbc_pkg::in_item_t    in_data,
  input  wire nbc_pkg::dp_cmd_t     cmd,
  output nbc_pkg::dp_status_t       status,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output nbc_pkg::out_item_t        out_data
);

  localparam int CW    = COUNT_WIDTH;
  localparam int LW    = LINE_LENGTH_WIDTH;
  localparam int SQ_W  = 2 * LW;
  localparam int SUM_W = ((CW > SQ_W) ? CW : SQ_W) + 1;
  localparam int NC    = nbc_pkg::NUM_COUNTERS;
  localparam logic [CW-1:0]    CMAX    = {CW{1'b1}};
  localparam logic [LW-1:0]    LMAX    = {LW{1'b1}};
  localparam logic [SUM_W-1:0] CMAX_EXT = SUM_W'(CMAX);

  logic [CW-1:0]   cnt_r [NC];
  logic [CW-1:0]   cnt_nxt [NC];
  logic [LW-1:0]   len_r, len_nxt;
  logic [2:0]      pend_r, pend_nxt;
  logic            pos_r, pos_nxt;
  logic [SQ_W-1:0] sq_r;
  logic            out_valid_r, out_valid_nxt;
  nbc_pkg::out_item_t out_data_r;

  logic [2:0]       sym_code;
  logic [3:0]       bigram;
  logic [SUM_W-1:0] len_sum, sq_sum;
  logic [63:0]      head_wide;

  assign sym_code = nbc_pkg::code_of(in_data.symbol);
  assign bigram   = {pend_r[1:0], sym_code[1:0]};
  assign len_sum  = SUM_W'(cnt_r[nbc_pkg::IDX_LENGTH]) + SUM_W'(len_r);
  assign sq_sum   = SUM_W'(cnt_r[nbc_pkg::IDX_SQUARE]) + SUM_W'(sq_r);
  assign head_wide = 64'(cnt_r[0]);

  always_comb begin
    cnt_nxt  = cnt_r;
    len_nxt  = len_r;
    pend_nxt = pend_r;
    pos_nxt  = pos_r;
    if (cmd.shift_en) begin
      // Readout walks the counters down the chain and fills zeros behind.
      for (int i = 0; i < NC - 1; i++) begin
        cnt_nxt[i] = cnt_r[i + 1];
      end
      cnt_nxt[NC - 1] = '0;
    end
    if (cmd.char_en) begin
      if (len_r != LMAX) begin
        len_nxt = len_r + 1'b1;
      end
      for (int i = 0; i < 4; i++) begin
        if (sym_code[2] && sym_code[1:0] == 2'(i) && cnt_r[i] != CMAX) begin
          cnt_nxt[i] = cnt_r[i] + 1'b1;
        end
      end
      if (!pos_r) begin
        pend_nxt = sym_code[2] ? sym_code : 3'b000;
        pos_nxt  = 1'b1;
      end else begin
        for (int j = 0; j < 16; j++) begin
          if (pend_r[2] && sym_code[2] && bigram == 4'(j) &&
              cnt_r[nbc_pkg::IDX_BIGRAM0 + j] != CMAX) begin
            cnt_nxt[nbc_pkg::IDX_BIGRAM0 + j] = cnt_r[nbc_pkg::IDX_BIGRAM0 + j] + 1'b1;
          end
        end
        pend_nxt = 3'b000;
        pos_nxt  = 1'b0;
      end
    end
    if (cmd.eol_en) begin
      if (cnt_r[nbc_pkg::IDX_LINES] != CMAX) begin
        cnt_nxt[nbc_pkg::IDX_LINES] = cnt_r[nbc_pkg::IDX_LINES] + 1'b1;
      end
      cnt_nxt[nbc_pkg::IDX_LENGTH] = (len_sum > CMAX_EXT) ? CMAX : len_sum[CW-1:0];
      len_nxt  = '0;
      pend_nxt = 3'b000;
      pos_nxt  = 1'b0;
    end
    if (cmd.sq_en) begin
      cnt_nxt[nbc_pkg::IDX_SQUARE] = (sq_sum > CMAX_EXT) ? CMAX : sq_sum[CW-1:0];
    end
  end

  assign out_valid_nxt = cmd.shift_en ? 1'b1 : (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NC; i++) begin
        cnt_r[i] <= '0;
      end
      len_r       <= '0;
      pend_r      <= 3'b000;
      pos_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      len_r       <= len_nxt;
      pend_r      <= pend_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eol_en) begin
      sq_r <= len_r * len_r;
    end
    if (cmd.shift_en) begin
      out_data_r.counter_index <= cmd.index;
      out_data_r.count_value   <= head_wide[nbc_pkg::VALUE_W-1:0];
      out_data_r.last          <= cmd.last;
    end
  end

  assign status.out_free = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;

endmodule

`default_nettype wire

FILE: bench/tb_nucleotide_bigram_counter.sv
`timescale 1ns / 1ps

module tb_nucleotide_bigram_counter;

  // The block is driven through its valid/ready input channel with
  // characters, end-of-line items, readout requests and the unused op code.
  // A scoreboard class keeps its own copy of every counter and of the line in
  // progress. For each accepted item it updates that copy, and for a readout
  // it queues the 23 counter values the block must emit. Every item taken from
  // the output channel is compared field by field with the oldest queued value.
  //
  // The run starts with a short directed sequence. Then comes one longer
  // line. Random traffic follows in four idling phases.

  // The fourth op code is accepted and ignored by the block.
  localparam logic [1:0]  OP_UNUSED       = 2'd3;
  localparam logic [47:0] COUNT_MAX       = {48{1'b1}};
  localparam logic [15:0] LINE_LEN_MAX    = {16{1'b1}};
  localparam int          LONG_LINE_CHARS = 40;
  localparam int          PHASE_ITEMS     = 65;
  localparam int          MAX_REPORTS     = 10;
  // A readout is 23 output items, so this is ample
  // time for any stray item to show up after the queue has emptied.
  localparam int          SETTLE_CYCLES   = 40;

  // Mirror of the block's counters. It also holds the values the block owes
  // for every readout that has been accepted.
  class bigram_tally;
    bit [47:0] base_count [4];
    bit [47:0] pair_count [16];
    bit [47:0] line_count;
    bit [47:0] length_sum;
    bit [47:0] square_sum;
    bit [15:0] line_len;
    // Bit 2 marks a held nucleotide at an even position, bits 1-0 its code.
    bit [2:0]  held_base;
    bit        odd_slot;
    nbc_pkg::out_item_t readout_q [$];
    int        mismatches;
    int        results_checked;
    int        readouts;
    int        lines_seen;
    int        items_noted;

    function new();
      mismatches      = 0;
      results_checked = 0;
      readouts        = 0;
      lines_seen      = 0;
      items_noted     = 0;
      clear_counts();
      line_len  = '0;
      held_base = '0;
      odd_slot  = 1'b0;
    endfunction

    function void clear_counts();
      foreach (base_count[i]) base_count[i] = '0;
      foreach (pair_count[i]) pair_count[i] = '0;
      line_count = '0;
      length_sum = '0;
      square_sum = '0;
    endfunction

    // The counters are exactly 48 bits wide, so a carry out means saturation.
    function bit [47:0] sat_add(bit [47:0] acc, bit [47:0] x);
      bit [48:0] sum;
      sum = {1'b0, acc} + {1'b0, x};
      return sum[48] ? COUNT_MAX : sum[47:0];
    endfunction

    // Lower case folds to upper case; only A, C, T and G are nucleotides.
    function bit [2:0] base_of(bit [7:0] ch);
      bit [7:0] up;
      up = (ch >= 8'h61 && ch <= 8'h7a) ? ch - 8'd32 : ch;
      case (up)
        nbc_pkg::CHAR_A: return 3'b100;
        nbc_pkg::CHAR_C: return 3'b101;
        nbc_pkg::CHAR_T: return 3'b110;
        nbc_pkg::CHAR_G: return 3'b111;
        default:         return 3'b000;
      endcase
    endfunction

    function void note_item(nbc_pkg::in_item_t it);
      bit [2:0]  b;
      bit [31:0] sq;
      nbc_pkg::out_item_t e;
      items_noted++;
      case (it.op)
        nbc_pkg::OP_CHAR: begin
          b = base_of(it.symbol);
          if (line_len != LINE_LEN_MAX) line_len++;
          if (b[2]) base_count[b[1:0]] = sat_add(base_count[b[1:0]], 48'd1);
          if (!odd_slot) begin
            held_base = b;
            odd_slot  = 1'b1;
          end else begin
            if (held_base[2] && b[2]) begin
              pair_count[{held_base[1:0], b[1:0]}] =
                sat_add(pair_count[{held_base[1:0], b[1:0]}], 48'd1);
            end
            held_base = '0;
            odd_slot  = 1'b0;
          end
        end
        nbc_pkg::OP_EOL: begin
          sq         = {16'd0, line_len} * {16'd0, line_len};
          line_count = sat_add(line_count, 48'd1);
          length_sum = sat_add(length_sum, {32'd0, line_len});
          square_sum = sat_add(square_sum, {16'd0, sq});
          lines_seen++;
          // An incomplete pair is dropped at the end of the line.
          line_len  = '0;
          held_base = '0;
          odd_slot  = 1'b0;
        end
        nbc_pkg::OP_READOUT: begin
          readouts++;
          for (int k = 0; k < nbc_pkg::NUM_COUNTERS; k++) begin
            e.counter_index = k[nbc_pkg::INDEX_W-1:0];
            e.last          = (k == nbc_pkg::NUM_COUNTERS - 1);
            if (k < nbc_pkg::IDX_BIGRAM0) begin
              e.count_value = base_count[k];
            end else if (k < nbc_pkg::IDX_LINES) begin
              e.count_value = pair_count[k - nbc_pkg::IDX_BIGRAM0];
            end else if (k == nbc_pkg::IDX_LINES) begin
              e.count_value = line_count;
            end else if (k == nbc_pkg::IDX_LENGTH) begin
              e.count_value = length_sum;
            end else begin
              e.count_value = square_sum;
            end
            readout_q.push_back(e);
          end
          // The line in progress survives a readout.
          clear_counts();
        end
        default: ;
      endcase
    endfunction

    function void check_readout(nbc_pkg::out_item_t got);
      nbc_pkg::out_item_t want;
      results_checked++;
      if (readout_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("Unexpected result: index %0d value %0d last %0b",
                   got.counter_index, got.count_value, got.last);
        return;
      end
      want = readout_q.pop_front();
      if (got.counter_index !== want.counter_index ||
          got.count_value !== want.count_value || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display({"Result %0d wrong: expected index %0d value %0d last %0b, ",
                    "got index %0d value %0d last %0b"},
                   results_checked, want.counter_index, want.count_value,
                   want.last, got.counter_index, got.count_value, got.last);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  nbc_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  nbc_pkg::out_item_t out_data;

  bigram_tally tally;
  int          send_idle_pct;
  int          recv_stall_pct;

  nucleotide_bigram_counter uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // The receiver decides at every falling edge whether it takes an item at
  // the next rising edge.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Every item the block hands over is checked at the edge where it is taken.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      tally.check_readout(out_data);
    end
  end

  // Presents one item, starting at a falling edge. Random idle cycles may come
  // first, with junk on the data bus while valid is low. Once valid is raised,
  // it holds with a stable payload until the block takes the item. The task
  // returns at the next falling edge with valid low; a following item raises
  // it again at that same instant, so back-to-back items see no gap.
  task automatic send_op(input logic [1:0] op, input logic [7:0] sym);
    nbc_pkg::in_item_t it;
    it.op     = op;
    it.symbol = sym;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid       = 1'b0;
      in_data.op     = 2'($urandom);
      in_data.symbol = 8'($urandom);
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (!in_ready);
    tally.note_item(it);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Mostly nucleotides in either case, then other letters, then any byte.
  function automatic logic [7:0] pick_symbol();
    logic [7:0] ch;
    int         r;
    r = $urandom_range(99);
    if (r < 70) begin
      case ($urandom_range(3))
        0:       ch = nbc_pkg::CHAR_A;
        1:       ch = nbc_pkg::CHAR_C;
        2:       ch = nbc_pkg::CHAR_T;
        default: ch = nbc_pkg::CHAR_G;
      endcase
      if ($urandom_range(1)) ch = ch | 8'h20;
    end else if (r < 85) begin
      ch = 8'h41 + 8'($urandom_range(25));
      if ($urandom_range(1)) ch = ch | 8'h20;
    end else begin
      ch = 8'($urandom);
    end
    return ch;
  endfunction

  // Waits until the block has delivered every owed counter value.
  task automatic drain();
    while (tally.readout_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Random lines of mostly short length, sometimes left open into a readout,
  // with the odd ignored op mixed in. Each phase ends on a readout so that
  // the last counts are checked before the idling pattern changes.
  task automatic random_phase(input int idle_pct, input int stall_pct);
    int budget;
    int n;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    budget = 0;
    while (budget < PHASE_ITEMS) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      for (int k = 0; k < n; k++) send_op(nbc_pkg::OP_CHAR, pick_symbol());
      budget += n;
      if ($urandom_range(9) != 0) begin
        send_op(nbc_pkg::OP_EOL, 8'($urandom));
        budget++;
      end
      if ($urandom_range(11) == 0) send_op(OP_UNUSED, 8'($urandom));
      if ($urandom_range(4) == 0) begin
        send_op(nbc_pkg::OP_READOUT, 8'($urandom));
        budget++;
      end
    end
    send_op(nbc_pkg::OP_READOUT, 8'($urandom));
    drain();
  endtask

  initial begin
    tally          = new();
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_ready      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed sequence, without idling. A readout straight after reset
    // must report all zeros.
    send_op(nbc_pkg::OP_READOUT, 8'h00);
    // The pairs A-c and g-T are bigrams. The pair N-A is not, although the
    // A still counts as a nucleotide.
    send_op(nbc_pkg::OP_CHAR, nbc_pkg::CHAR_A);
    send_op(nbc_pkg::OP_CHAR, nbc_pkg::CHAR_C | 8'h20);
    send_op(nbc_pkg::OP_CHAR, nbc_pkg::CHAR_G | 8'h20);
    send_op(nbc_pkg::OP_CHAR, nbc_pkg::CHAR_T);
    send_op(nbc_pkg::OP_CHAR, 8'h4e);
    send_op(nbc_pkg::OP_CHAR, nbc_pkg::CHAR_A);
    // A lone G is left pending when the line closes, so its pair is dropped.
    send_op(nbc_pkg::OP_CHAR, nbc_pkg::CHAR_G);
    send_op(nbc_pkg::OP_EOL, 8'hff);
    // This is an empty line of length zero.
    send_op(nbc_pkg::OP_EOL, 8'h00);
    // The readout falls in the middle of a pair. The T and the line length
    // carry over, so T-C still counts afterwards.
    send_op(nbc_pkg::OP_CHAR, nbc_pkg::CHAR_T);
    send_op(nbc_pkg::OP_READOUT, 8'hff);
    send_op(nbc_pkg::OP_CHAR, nbc_pkg::CHAR_C);
    send_op(OP_UNUSED, 8'hff);
    send_op(OP_UNUSED, 8'h00);
    // These bytes test the case folding at its edges, and bytes that must
    // not fold.
    send_op(nbc_pkg::OP_CHAR, 8'h00);
    send_op(nbc_pkg::OP_CHAR, 8'hff);
    send_op(nbc_pkg::OP_CHAR, 8'h60);
    send_op(nbc_pkg::OP_CHAR, 8'h7b);
    send_op(nbc_pkg::OP_CHAR, 8'h7a);
    send_op(nbc_pkg::OP_CHAR, 8'h61);
    send_op(nbc_pkg::OP_CHAR, nbc_pkg::CHAR_A | 8'h80);
    send_op(nbc_pkg::OP_EOL, 8'h55);
    send_op(nbc_pkg::OP_READOUT, 8'haa);
    drain();

    // One longer line of mixed symbols, read out on its own.
    for (int k = 0; k < LONG_LINE_CHARS; k++) send_op(nbc_pkg::OP_CHAR, pick_symbol());
    send_op(nbc_pkg::OP_EOL, 8'h00);
    send_op(nbc_pkg::OP_READOUT, 8'h00);
    drain();

    random_phase(0, 0);
    random_phase(47, 0);
    random_phase(0, 47);
    random_phase(14, 14);

    in_valid = 1'b0;
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (tally.readout_q.size() != 0)
      $display("%0d counter values never came out", tally.readout_q.size());
    $display("Accepted %0d items in %0d lines, with %0d readouts.",
             tally.items_noted, tally.lines_seen, tally.readouts);
    $display("Checked %0d counter values. %0d of them were wrong or unexpected.",
             tally.results_checked, tally.mismatches);
    if (tally.mismatches == 0 && tally.readout_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // A correct run takes well under a millisecond of simulated time. This
  // limit leaves several times that margin.
  initial begin
    #5_000_000;
    $display("Timed out with %0d counter values still owed", tally.readout_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
